// ----- rtl/ptl_pkg.sv -----
// Shared types and constants for the PDF token lexer.
`timescale 1ns / 1ps

package ptl_pkg;

    // Width of the byte position and token length counters.
    localparam int POSITION_BITS = 32;
    localparam int FIELD_BITS    = 32;
    localparam int QUEUE_DEPTH   = 4;
    localparam int QUEUE_AW      = $clog2(QUEUE_DEPTH);
    localparam int MAX_RESULTS   = 3;

    typedef enum logic [2:0] {
        KIND_INT   = 3'd0,
        KIND_REAL  = 3'd1,
        KIND_NAME  = 3'd2,
        KIND_WORD  = 3'd3,
        KIND_DELIM = 3'd4,
        KIND_DONE  = 3'd5,
        KIND_NONE  = 3'd7
    } kind_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_valid;
        logic       end_of_buffer;
    } in_item_t;

    typedef struct packed {
        logic [2:0]            token_kind;
        logic [FIELD_BITS-1:0] token_position;
        logic [FIELD_BITS-1:0] token_length;
        logic                  last_of_run;
    } out_item_t;

    // One token as produced by the front end, before the last-of-run mark.
    typedef struct packed {
        logic [2:0]            kind;
        logic [FIELD_BITS-1:0] position;
        logic [FIELD_BITS-1:0] length;
    } token_t;

    // All results caused by one input item; count runs from 1 to MAX_RESULTS.
    typedef struct packed {
        logic [1:0]                   count;
        token_t [MAX_RESULTS-1:0]     tokens;
    } group_t;

    typedef struct packed {
        logic   write;
        group_t group;
    } group_wr_t;

endpackage

// ----- rtl/ptl_front.sv -----
// Front end: takes bytes, tracks the open token and builds result groups.
`timescale 1ns / 1ps

module ptl_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 accept,
    input  ptl_pkg::in_item_t    item,
    output ptl_pkg::group_wr_t   group_wr
);

    localparam int PW = ptl_pkg::POSITION_BITS;

    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_LF      = 8'h0A;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_BANG    = 8'h21;
    localparam logic [7:0] CH_TILDE   = 8'h7E;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_DOT     = 8'h2E;
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_LT      = 8'h3C;
    localparam logic [7:0] CH_GT      = 8'h3E;
    localparam logic [7:0] CH_LBRACK  = 8'h5B;
    localparam logic [7:0] CH_RBRACK  = 8'h5D;
    localparam logic [7:0] CH_LPAREN  = 8'h28;
    localparam logic [7:0] CH_RPAREN  = 8'h29;
    localparam logic [7:0] CH_LBRACE  = 8'h7B;
    localparam logic [7:0] CH_RBRACE  = 8'h7D;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;

    typedef struct packed {
        logic            brk;
        ptl_pkg::kind_t  kind;
    } step_t;

    function automatic logic is_digit(logic [7:0] ch);
        return (ch >= CH_ZERO) && (ch <= CH_NINE);
    endfunction

    function automatic logic is_blank(logic [7:0] ch);
        return ch inside {8'h00, CH_SPACE, [8'h09:CH_CR]};
    endfunction

    function automatic logic [PW-1:0] sat_inc(logic [PW-1:0] v);
        return (&v) ? v : v + PW'(1);
    endfunction

    // Kind after taking ch into a token of kind k; KIND_NONE means first byte.
    function automatic step_t next_kind(ptl_pkg::kind_t k, logic [7:0] ch,
                                        logic len_one, logic [7:0] prev);
        step_t r;
        r.brk  = 1'b0;
        r.kind = k;
        if (is_digit(ch)) begin
            if (k == ptl_pkg::KIND_DELIM)
                r.brk = 1'b1;
            else if (k == ptl_pkg::KIND_NONE)
                r.kind = ptl_pkg::KIND_INT;
        end
        else begin
            case (ch)
                CH_PLUS, CH_MINUS:
                begin
                    if (k == ptl_pkg::KIND_NONE)
                        r.kind = ptl_pkg::KIND_INT;
                    else if (k == ptl_pkg::KIND_INT || k == ptl_pkg::KIND_REAL)
                        r.kind = ptl_pkg::KIND_WORD;
                    else if (k == ptl_pkg::KIND_DELIM)
                        r.brk = 1'b1;
                end
                CH_DOT:
                begin
                    if (k == ptl_pkg::KIND_NONE || k == ptl_pkg::KIND_INT)
                        r.kind = ptl_pkg::KIND_REAL;
                    else if (k == ptl_pkg::KIND_REAL)
                        r.kind = ptl_pkg::KIND_WORD;
                    else if (k == ptl_pkg::KIND_DELIM)
                        r.brk = 1'b1;
                end
                CH_SLASH:
                begin
                    if (k == ptl_pkg::KIND_NONE)
                        r.kind = ptl_pkg::KIND_NAME;
                    else
                        r.brk = 1'b1;
                end
                CH_LT, CH_GT:
                begin
                    // Only a doubled angle bracket extends a token.
                    if (k == ptl_pkg::KIND_NONE)
                        r.kind = ptl_pkg::KIND_DELIM;
                    else if (!(len_one && prev == ch))
                        r.brk = 1'b1;
                end
                CH_LBRACK, CH_RBRACK, CH_LPAREN, CH_RPAREN, CH_LBRACE, CH_RBRACE:
                begin
                    if (k == ptl_pkg::KIND_NONE)
                        r.kind = ptl_pkg::KIND_DELIM;
                    else
                        r.brk = 1'b1;
                end
                default:
                begin
                    if (is_blank(ch) || ch == CH_PERCENT)
                        r.brk = 1'b1;
                    else if (k == ptl_pkg::KIND_NAME) begin
                        if (ch < CH_BANG || ch > CH_TILDE)
                            r.kind = ptl_pkg::KIND_WORD;
                    end
                    else if (k == ptl_pkg::KIND_DELIM)
                        r.brk = 1'b1;
                    else
                        r.kind = ptl_pkg::KIND_WORD;
                end
            endcase
        end
        return r;
    endfunction

    function automatic ptl_pkg::token_t make_token(ptl_pkg::kind_t k, logic seen,
                                                   logic [PW-1:0] start,
                                                   logic [PW-1:0] len);
        ptl_pkg::token_t t;
        ptl_pkg::kind_t  kk;
        kk = k;
        if ((k == ptl_pkg::KIND_INT || k == ptl_pkg::KIND_REAL) && !seen)
            kk = ptl_pkg::KIND_WORD;
        t.kind     = kk;
        t.position = ptl_pkg::FIELD_BITS'(start);
        t.length   = ptl_pkg::FIELD_BITS'(len);
        return t;
    endfunction

    logic [PW-1:0]   position_reg, position_next;
    logic            comment_reg, comment_next;
    ptl_pkg::kind_t  kind_reg, kind_next;
    logic [PW-1:0]   start_reg, start_next;
    logic [PW-1:0]   length_reg, length_next;
    logic [7:0]      prev_reg, prev_next;
    logic            seen_reg, seen_next;

    ptl_pkg::group_t group;
    logic [1:0]      n;
    step_t           step;
    step_t           first_step;
    logic            taken;
    logic [7:0]      ch;

    always_comb
    begin
        position_next = position_reg;
        comment_next  = comment_reg;
        kind_next     = kind_reg;
        start_next    = start_reg;
        length_next   = length_reg;
        prev_next     = prev_reg;
        seen_next     = seen_reg;
        group         = '0;
        n             = 2'd0;
        taken         = 1'b0;
        ch            = item.data_byte;
        step = next_kind(kind_reg, ch, length_reg == PW'(1), prev_reg);
        first_step = next_kind(ptl_pkg::KIND_NONE, ch, 1'b0, CH_SPACE);

        if (item.byte_valid) begin
            if (kind_reg != ptl_pkg::KIND_NONE) begin
                if (step.brk) begin
                    group.tokens[n] = make_token(kind_reg, seen_reg, start_reg, length_reg);
                    n         = n + 2'd1;
                    kind_next = ptl_pkg::KIND_NONE;
                end
                else begin
                    kind_next   = step.kind;
                    length_next = sat_inc(length_reg);
                    if (is_digit(ch))
                        seen_next = 1'b1;
                    taken = 1'b1;
                end
            end
            // The breaking byte is then handled as the first byte after the token.
            if (!taken) begin
                if (comment_reg) begin
                    if (ch == CH_LF || ch == CH_CR)
                        comment_next = 1'b0;
                end
                else if (ch == CH_PERCENT)
                    comment_next = 1'b1;
                else if (!is_blank(ch)) begin
                    kind_next   = first_step.kind;
                    start_next  = position_reg;
                    length_next = PW'(1);
                    seen_next   = is_digit(ch);
                end
            end
            prev_next     = ch;
            position_next = sat_inc(position_reg);
        end

        if (item.end_of_buffer) begin
            if (kind_next != ptl_pkg::KIND_NONE) begin
                group.tokens[n] = make_token(kind_next, seen_next, start_next, length_next);
                n = n + 2'd1;
            end
            group.tokens[n].kind     = ptl_pkg::KIND_DONE;
            group.tokens[n].position = ptl_pkg::FIELD_BITS'(position_next);
            group.tokens[n].length   = '0;
            n = n + 2'd1;
            // Start the next buffer from a clean state.
            position_next = '0;
            comment_next  = 1'b0;
            kind_next     = ptl_pkg::KIND_NONE;
            start_next    = '0;
            length_next   = '0;
            prev_next     = CH_SPACE;
            seen_next     = 1'b0;
        end
        group.count = n;
    end

    assign group_wr.write = accept && (n != 2'd0);
    assign group_wr.group = group;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            position_reg <= '0;
            comment_reg  <= 1'b0;
            kind_reg     <= ptl_pkg::KIND_NONE;
            start_reg    <= '0;
            length_reg   <= '0;
            prev_reg     <= CH_SPACE;
            seen_reg     <= 1'b0;
        end
        else if (accept) begin
            position_reg <= position_next;
            comment_reg  <= comment_next;
            kind_reg     <= kind_next;
            start_reg    <= start_next;
            length_reg   <= length_next;
            prev_reg     <= prev_next;
            seen_reg     <= seen_next;
        end
    end

endmodule

// ----- rtl/ptl_queue.sv -----
// Short queue of result groups between the front and back ends.
`timescale 1ns / 1ps

module ptl_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  ptl_pkg::group_wr_t  group_wr,
    input  logic                release_head,
    output ptl_pkg::group_t     head,
    output logic                full,
    output logic                empty
);

    localparam int AW = ptl_pkg::QUEUE_AW;

    ptl_pkg::group_t mem [ptl_pkg::QUEUE_DEPTH];

    logic [AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [AW:0]   count_reg, count_next;
    logic          do_write, do_read;

    assign full     = (count_reg == (AW+1)'(ptl_pkg::QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign do_write = group_wr.write && !full;
    assign do_read  = release_head && !empty;
    assign head     = mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (do_write && !do_read)
            count_next = count_reg + (AW+1)'(1);
        else if (do_read && !do_write)
            count_next = count_reg - (AW+1)'(1);
    end

    always_ff @(posedge clk)
    begin
        if (do_write)
            mem[wr_ptr_reg] <= group_wr.group;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else begin
            if (do_write)
                wr_ptr_reg <= wr_ptr_reg + AW'(1);
            if (do_read)
                rd_ptr_reg <= rd_ptr_reg + AW'(1);
            count_reg <= count_next;
        end
    end

endmodule

// ----- rtl/ptl_back.sv -----
// Back end: hands out the results of each queued group one at a time.
`timescale 1ns / 1ps

module ptl_back (
    input  logic                clk,
    input  logic                rst_n,
    input  ptl_pkg::group_t     head,
    input  logic                head_empty,
    input  logic                pop,
    output logic                release_head,
    output ptl_pkg::out_item_t  result
);

    logic [1:0]      index_reg, index_next;
    logic            last;
    ptl_pkg::token_t tok;

    assign tok  = head.tokens[index_reg];
    assign last = (index_reg == head.count - 2'd1);

    assign result.token_kind     = tok.kind;
    assign result.token_position = tok.position;
    assign result.token_length   = tok.length;
    assign result.last_of_run    = last;

    assign release_head = pop && !head_empty && last;

    always_comb
    begin
        index_next = index_reg;
        if (pop && !head_empty)
            index_next = last ? 2'd0 : index_reg + 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            index_reg <= 2'd0;
        else
            index_reg <= index_next;
    end

endmodule

// ----- rtl/pdf_token_lexer.sv -----
// Top level of the PDF token lexer.
//
//  channel  | handshake          | payload
//  ---------+--------------------+---------------------------------------------
//  input    | push / full        | item   : data_byte, byte_valid, end_of_buffer
//  result   | empty / pop        | result : token_kind, token_position,
//           |                    |          token_length, last_of_run
//
// One byte is taken per cycle unless full; the lexer state updates as it is taken.
// An item's results (up to three) are queued together as one group and
// leave at one per popped cycle, so the result side sets the sustained rate.
// full rises only when the four-group queue between front and back is full.
// Reset clears the lexer state and empties the queue.
`timescale 1ns / 1ps

module pdf_token_lexer (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  ptl_pkg::in_item_t   item,
    output logic                empty,
    input  logic                pop,
    output ptl_pkg::out_item_t  result
);

    ptl_pkg::group_wr_t group_wr;
    ptl_pkg::group_t    head;
    logic               release_head;
    logic               accept;

    assign accept = push && !full;

    ptl_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .item     (item),
        .group_wr (group_wr)
    );

    ptl_queue u_queue (
        .clk          (clk),
        .rst_n        (rst_n),
        .group_wr     (group_wr),
        .release_head (release_head),
        .head         (head),
        .full         (full),
        .empty        (empty)
    );

    ptl_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .head_empty   (empty),
        .pop          (pop),
        .release_head (release_head),
        .result       (result)
    );

endmodule

// ----- rtl/ptl_checker.sv -----
// Port-level checks for the PDF token lexer and their bind.
`timescale 1ns / 1ps

module ptl_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                push,
    input logic                full,
    input ptl_pkg::in_item_t   item,
    input logic                empty,
    input logic                pop,
    input ptl_pkg::out_item_t  result
);

    // Hold a waiting result steady until it is taken.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(result)))
        else $error("waiting result changed before pop");

    a_kind: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (result.token_kind <= 3'(ptl_pkg::KIND_DONE)))
        else $error("result kind out of range");

    // DONE closes a run and carries no length.
    a_done: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.token_kind == 3'(ptl_pkg::KIND_DONE))
            |-> (result.last_of_run && result.token_length == '0))
        else $error("DONE result malformed");

    // More results of the same item follow at once.
    a_run: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && pop && !result.last_of_run) |=> !empty)
        else $error("run of results cut short");

    a_item_known: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !full) |-> !$isunknown(item))
        else $error("accepted item has unknown bits");

endmodule

bind pdf_token_lexer ptl_checker u_ptl_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .full   (full),
    .item   (item),
    .empty  (empty),
    .pop    (pop),
    .result (result)
);

// ----- tb/tb_top.sv -----
// Self-checking testbench for the PDF token lexer: byte stream in, token records out.
`timescale 1ns / 1ps

module tb_top;
    import ptl_pkg::*;

    localparam int CLK_PERIOD   = 20;
    localparam int RANDOM_ITEMS = 470;
    localparam int TAIL_CYCLES  = 16;
    localparam int LIMIT_CYCLES = 200_000;

    localparam logic [7:0] CH_PERCENT = "%";
    localparam logic [7:0] CH_LF      = 8'h0A;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_BANG    = "!";
    localparam logic [7:0] CH_TILDE   = "~";

    localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

    logic       clk   = 1'b0;
    logic       rst_n = 1'b0;
    logic       push  = 1'b0;
    logic       pop   = 1'b0;
    logic       full;
    logic       empty;
    in_item_t   item  = '0;
    out_item_t  result;

    pdf_token_lexer i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (full),
        .item   (item),
        .empty  (empty),
        .pop    (pop),
        .result (result)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Lexer state mirrored by the predictor.
    logic [POSITION_BITS-1:0] lx_pos;
    logic [POSITION_BITS-1:0] lx_start;
    logic [POSITION_BITS-1:0] lx_len;
    logic                     lx_comment;
    logic                     lx_digit;
    logic [7:0]               lx_prev;
    kind_t                    lx_kind;

    in_item_t  byte_stream[$];
    out_item_t expected_tokens[$];

    int  sent_count     = 0;
    bit  took_item      = 1'b0;
    int  mismatches     = 0;
    int  tokens_checked = 0;
    int  buffers_done   = 0;

    function automatic logic is_blank(input logic [7:0] ch);
        return ch == 8'h00 || ch == 8'h20 || (ch >= 8'h09 && ch <= 8'h0D);
    endfunction

    function automatic logic is_digit(input logic [7:0] ch);
        return ch >= "0" && ch <= "9";
    endfunction

    function automatic logic [POSITION_BITS-1:0] sat_inc(input logic [POSITION_BITS-1:0] v);
        return (v == POS_MAX) ? v : v + 1'b1;
    endfunction

    // Return 1 when ch cannot join a token of kind k; otherwise grown_kind is the new kind.
    function automatic logic token_breaks(input kind_t k, input logic [7:0] ch,
                                          output kind_t grown_kind);
        grown_kind = k;
        if (is_digit(ch))
        begin
            if (k == KIND_DELIM)
                return 1'b1;
            grown_kind = (k == KIND_NONE) ? KIND_INT : k;
            return 1'b0;
        end
        case (ch)
            "+", "-":
            begin
                if (k == KIND_NONE)
                    grown_kind = KIND_INT;
                else if (k == KIND_INT || k == KIND_REAL)
                    grown_kind = KIND_WORD;
                else if (k == KIND_DELIM)
                    return 1'b1;
                return 1'b0;
            end
            ".":
            begin
                if (k == KIND_NONE || k == KIND_INT)
                    grown_kind = KIND_REAL;
                else if (k == KIND_REAL)
                    grown_kind = KIND_WORD;
                else if (k == KIND_DELIM)
                    return 1'b1;
                return 1'b0;
            end
            "/":
            begin
                grown_kind = KIND_NAME;
                return k != KIND_NONE;
            end
            "<", ">":
            begin
                if (k == KIND_NONE)
                begin
                    grown_kind = KIND_DELIM;
                    return 1'b0;
                end
                // only a doubled angle bracket stays one token
                return !(lx_len == 1 && lx_prev == ch);
            end
            "[", "]", "(", ")", "{", "}":
            begin
                grown_kind = KIND_DELIM;
                return k != KIND_NONE;
            end
            default: ;
        endcase
        if (is_blank(ch) || ch == CH_PERCENT)
            return 1'b1;
        if (k == KIND_NAME)
        begin
            grown_kind = (ch < CH_BANG || ch > CH_TILDE) ? KIND_WORD : KIND_NAME;
            return 1'b0;
        end
        if (k == KIND_DELIM)
            return 1'b1;
        grown_kind = KIND_WORD;
        return 1'b0;
    endfunction

    task automatic lexer_clear();
        lx_pos     = '0;
        lx_start   = '0;
        lx_len     = '0;
        lx_comment = 1'b0;
        lx_digit   = 1'b0;
        lx_prev    = " ";
        lx_kind    = KIND_NONE;
    endtask

    task automatic emit_open_token();
        kind_t k;
        k = lx_kind;
        if ((k == KIND_INT || k == KIND_REAL) && !lx_digit)
            k = KIND_WORD;
        expected_tokens.push_back('{k, FIELD_BITS'(lx_start), FIELD_BITS'(lx_len), 1'b0});
        lx_kind = KIND_NONE;
    endtask

    // Advance the lexer by one item and queue the token records it causes.
    task automatic lex_item(input in_item_t it);
        int        produced;
        logic      joined;
        kind_t     grown_kind;
        logic [7:0] ch;
        out_item_t tail;
        produced = 0;
        if (it.byte_valid)
        begin
            ch     = it.data_byte;
            joined = 1'b0;
            if (lx_kind != KIND_NONE)
            begin
                if (token_breaks(lx_kind, ch, grown_kind))
                begin
                    emit_open_token();
                    produced++;
                end
                else
                begin
                    lx_kind = grown_kind;
                    lx_len  = sat_inc(lx_len);
                    if (is_digit(ch))
                        lx_digit = 1'b1;
                    joined = 1'b1;
                end
            end
            if (!joined)
            begin
                if (lx_comment)
                begin
                    if (ch == CH_LF || ch == CH_CR)
                        lx_comment = 1'b0;
                end
                else if (ch == CH_PERCENT)
                    lx_comment = 1'b1;
                else if (!is_blank(ch))
                begin
                    void'(token_breaks(KIND_NONE, ch, grown_kind));
                    lx_kind  = grown_kind;
                    lx_start = lx_pos;
                    lx_len   = POSITION_BITS'(1);
                    lx_digit = is_digit(ch);
                end
            end
            lx_prev = ch;
            lx_pos  = sat_inc(lx_pos);
        end
        if (it.end_of_buffer)
        begin
            if (lx_kind != KIND_NONE)
            begin
                emit_open_token();
                produced++;
            end
            expected_tokens.push_back('{KIND_DONE, FIELD_BITS'(lx_pos), '0, 1'b0});
            produced++;
            lexer_clear();
        end
        if (produced > 0)
        begin
            tail = expected_tokens.pop_back();
            tail.last_of_run = 1'b1;
            expected_tokens.push_back(tail);
        end
    endtask

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        mismatches++;
    endtask

    task automatic check_token(input out_item_t got);
        out_item_t want;
        if (expected_tokens.size() == 0)
        begin
            report_mismatch($sformatf("unexpected token kind %0d pos %0d len %0d",
                                      got.token_kind, got.token_position, got.token_length));
            return;
        end
        want = expected_tokens.pop_front();
        tokens_checked++;
        if (want.token_kind == KIND_DONE)
            buffers_done++;
        if (got.token_kind !== want.token_kind)
            report_mismatch($sformatf("token_kind %0d, want %0d",
                                      got.token_kind, want.token_kind));
        if (got.token_position !== want.token_position)
            report_mismatch($sformatf("token_position %0d, want %0d",
                                      got.token_position, want.token_position));
        if (got.token_length !== want.token_length)
            report_mismatch($sformatf("token_length %0d, want %0d",
                                      got.token_length, want.token_length));
        if (got.last_of_run !== want.last_of_run)
            report_mismatch($sformatf("last_of_run %0b, want %0b",
                                      got.last_of_run, want.last_of_run));
    endtask

    // Sample both handshakes at the rising edge; predict before checking.
    always @(posedge clk)
    begin
        took_item = 1'b0;
        if (rst_n)
        begin
            if (push && !full)
            begin
                lex_item(item);
                sent_count++;
                took_item = 1'b1;
            end
            if (pop && !empty)
                check_token(result);
        end
    end

    // Sender: bursts of items separated by idle gaps.
    int burst_left = 12;
    int gap_left   = 0;

    always @(negedge clk)
    begin
        if (!rst_n)
            push <= 1'b0;
        else
        begin
            if (took_item)
            begin
                burst_left--;
                if (burst_left <= 0)
                begin
                    burst_left = $urandom_range(1, 24);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
            end
            if (gap_left > 0)
            begin
                gap_left--;
                push <= 1'b0;
            end
            else if (sent_count < byte_stream.size())
            begin
                push <= 1'b1;
                item <= byte_stream[sent_count];
            end
            else
                push <= 1'b0;
        end
    end

    // Receiver: pop follows a rotating pattern that is redrawn now and then.
    logic [15:0] pop_pattern = '1;
    int          pattern_age = 0;

    always @(negedge clk)
    begin
        if (!rst_n)
            pop <= 1'b0;
        else
        begin
            if (pattern_age <= 0)
            begin
                case ($urandom_range(0, 3))
                    0:       pop_pattern = '1;
                    1:       pop_pattern = 16'($urandom);
                    2:       pop_pattern = 16'($urandom & $urandom);
                    default: pop_pattern = 16'($urandom | $urandom);
                endcase
                if (pop_pattern == '0)
                    pop_pattern[0] = 1'b1;
                pattern_age = $urandom_range(16, 96);
            end
            pattern_age--;
            pop <= pop_pattern[0];
            pop_pattern = {pop_pattern[0], pop_pattern[15:1]};
        end
    end

    task automatic add_byte(input logic [7:0] b);
        byte_stream.push_back('{b, 1'b1, 1'b0});
    endtask

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++)
            add_byte(s[i]);
    endtask

    task automatic add_idle_item();
        byte_stream.push_back('{8'($urandom), 1'b0, 1'b0});
    endtask

    task automatic add_end_only();
        byte_stream.push_back('{8'($urandom), 1'b0, 1'b1});
    endtask

    task automatic mark_end();
        in_item_t tail;
        tail = byte_stream.pop_back();
        tail.end_of_buffer = 1'b1;
        byte_stream.push_back(tail);
    endtask

    task automatic add_blank();
        logic [7:0] blanks[7];
        blanks = '{8'h00, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D, 8'h20};
        add_byte(blanks[$urandom_range(0, 6)]);
    endtask

    // One lexical fragment with random content; most are well formed.
    task automatic add_fragment();
        string delims[10];
        int    n;
        delims = '{"<<", ">>", "<", ">", "[", "]", "(", ")", "{", "}"};
        case ($urandom_range(0, 11))
            0, 1:
            begin
                if ($urandom_range(0, 2) == 0)
                    add_byte($urandom_range(0, 1) ? "+" : "-");
                n = $urandom_range(0, 4);
                repeat (n) add_byte(8'($urandom_range("0", "9")));
                if ($urandom_range(0, 1))
                    add_byte(".");
                n = $urandom_range(0, 3);
                repeat (n) add_byte(8'($urandom_range("0", "9")));
                if ($urandom_range(0, 7) == 0)
                    add_byte($urandom_range(0, 1) ? "." : "+");
                else if (byte_stream[$].data_byte == 8'h00 || !byte_stream[$].byte_valid)
                    add_byte("1");
            end
            2, 3:
            begin
                add_byte("/");
                n = $urandom_range(0, 6);
                repeat (n) add_byte(8'($urandom_range(CH_BANG, CH_TILDE)));
                if ($urandom_range(0, 4) == 0)
                    add_byte($urandom_range(0, 1) ? 8'($urandom_range(8'h80, 8'hFF))
                                                  : 8'($urandom_range(8'h01, 8'h08)));
            end
            4:
            begin
                n = $urandom_range(1, 6);
                repeat (n) add_byte(8'($urandom_range("a", "z")));
            end
            5, 6:
                add_text(delims[$urandom_range(0, 9)]);
            7:
            begin
                add_byte(CH_PERCENT);
                n = $urandom_range(0, 5);
                repeat (n) add_byte(8'($urandom_range(0, 255)));
                if ($urandom_range(0, 5) != 0)
                    add_byte($urandom_range(0, 1) ? CH_CR : CH_LF);
            end
            8, 9:
            begin
                n = $urandom_range(1, 3);
                repeat (n) add_blank();
            end
            10:
            begin
                n = $urandom_range(1, 3);
                repeat (n) add_byte(8'($urandom_range(0, 255)));
            end
            default:
            begin
                n = $urandom_range(1, 5);
                repeat (n) add_byte(8'($urandom_range("0", "9")));
            end
        endcase
    endtask

    initial
    begin
        int start_size;
        int frags;
        lexer_clear();

        // Doubled and broken angle brackets, a name spoiled by a high byte,
        // a real ended by a comment, an idle item, and a lone dot flushed at end.
        add_text("<<<>/N");
        add_byte(8'hFF);
        add_text("(-.5%x");
        add_byte(CH_CR);
        add_idle_item();
        add_text(".");
        add_end_only();
        // Name broken by a comment that is still open at end of buffer.
        add_text("9}/A%q");
        mark_end();
        // Blanks, then one item that closes a token, opens one and ends the buffer.
        add_byte(8'h00);
        add_byte(8'h09);
        add_text("7)");
        mark_end();

        start_size = byte_stream.size();
        while (byte_stream.size() - start_size < RANDOM_ITEMS)
        begin
            frags = ($urandom_range(0, 7) == 0) ? 1 : $urandom_range(1, 10);
            repeat (frags)
            begin
                add_fragment();
                if ($urandom_range(0, 9) < 6)
                    add_blank();
                if ($urandom_range(0, 29) == 0)
                    add_idle_item();
            end
            if ($urandom_range(0, 1))
                mark_end();
            else
                add_end_only();
        end

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (sent_count < byte_stream.size() || expected_tokens.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("lexed %0d items in %0d buffers, %0d token records checked",
                 sent_count, buffers_done, tokens_checked);
        $display("%0d mismatches", mismatches);
        if (mismatches == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

    initial
    begin
        #(LIMIT_CYCLES * CLK_PERIOD);
        $display("timeout with %0d token records outstanding", expected_tokens.size());
        $display("tb_top NOT OK");
        $finish;
    end

endmodule
